>>> rtl/core/swrm_pkg.sv
// Shared constants and types for the sliding window rate meter.
// No dependencies; compile first.
package swrm_pkg;

  localparam int RING_DEPTH_DEF = 16;
  localparam int TIME_W         = 32;
  localparam int CNT_W          = 32;
  localparam int INTERVAL_W     = 16;
  localparam int SCALE_W        = 10;
  localparam int NUM_W          = CNT_W + SCALE_W;

  localparam logic [SCALE_W-1:0]    RATE_SCALE     = SCALE_W'(1000);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);
  localparam logic [TIME_W-1:0]     ELAPSED_MIN    = TIME_W'(1);

  typedef struct packed {
    logic [TIME_W-1:0] t_ms;
    logic [CNT_W-1:0]  sent;
    logic [CNT_W-1:0]  received;
  } snap_t;

  localparam int SNAP_W = $bits(snap_t);

endpackage

>>> rtl/core/swrm_ifs.sv
// Request channels of the rate meter: poll in, rate out, interval write.
// Depends on swrm_pkg.
interface swrm_poll_if
  import swrm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic [CNT_W-1:0]  sent_total;
  logic [CNT_W-1:0]  received_total;

  modport source (output valid, now_ms, sent_total, received_total, input ready);
  modport sink   (input valid, now_ms, sent_total, received_total, output ready);
endinterface

interface swrm_rate_if
  import swrm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] send_rate;
  logic [CNT_W-1:0] receive_rate;
  logic             snapshot_taken;

  modport source (output valid, send_rate, receive_rate, snapshot_taken, input ready);
  modport sink   (input valid, send_rate, receive_rate, snapshot_taken, output ready);
endinterface

interface swrm_cfg_if
  import swrm_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [INTERVAL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/swrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/swrm_div.sv
// Restoring divider, one quotient bit per cycle, saturating 32-bit quotient.
// Depends on swrm_pkg.
module swrm_div
  import swrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [CNT_W-1:0]  quot
);

  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] den_r;
  logic [NUM_W-1:0]  qsh;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;

  assign trial = {rem, qsh[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= LAST_STEP;
        rem   <= '0;
        qsh   <= num;
        den_r <= den;
      end else if (busy) begin
        // keep the trial remainder only when the subtraction does not borrow
        if (!diff[TIME_W]) begin
          rem <= diff[TIME_W-1:0];
          qsh <= {qsh[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[TIME_W-1:0];
          qsh <= {qsh[NUM_W-2:0], 1'b0};
        end
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

  assign quot = (|qsh[NUM_W-1:CNT_W]) ? '1 : qsh[CNT_W-1:0];

endmodule

>>> rtl/core/sliding_window_rate_meter.sv
// Sliding window byte-rate meter: a ring of (time, sent, received) snapshots
// in one RAM, one shared serial divider. Depends on swrm_pkg, swrm_ifs,
// swrm_ram and swrm_div.
//
// Each poll request passes from acceptance to its rate request through
// two RAM reads (oldest, then newest snapshot), then two 42-step
// divisions run one after the other on the single restoring divider.
// One poll is in work at a time; a new poll is taken while
// the previous rate request still waits in the output register. Snapshot
// entries read as zero until first written, tracked by one valid bit per
// entry, so no clearing pass follows reset. The interval register may be
// written in any cycle and is always ready.
module sliding_window_rate_meter
  import swrm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  swrm_poll_if.sink   poll,
  swrm_rate_if.source rate,
  swrm_cfg_if.sink    cfg
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_RD_OLD     = 8'b0000_0010,
    S_RD_NEW     = 8'b0000_0100,
    S_START_SEND = 8'b0000_1000,
    S_WAIT_SEND  = 8'b0001_0000,
    S_START_RECV = 8'b0010_0000,
    S_WAIT_RECV  = 8'b0100_0000,
    S_FINISH     = 8'b1000_0000
  } state_t;

  state_t                state;
  logic [AW-1:0]         pos;
  logic [RING_DEPTH-1:0] snap_valid;
  logic [INTERVAL_W-1:0] interval;

  logic [TIME_W-1:0] now_r;
  logic [CNT_W-1:0]  sent_r;
  logic [CNT_W-1:0]  recv_r;
  logic [TIME_W-1:0] elapsed;
  logic [CNT_W-1:0]  diff_sent;
  logic [CNT_W-1:0]  diff_recv;
  logic [NUM_W-1:0]  num;
  logic              taken;
  logic [CNT_W-1:0]  send_q;

  logic              out_valid;
  logic [CNT_W-1:0]  out_send;
  logic [CNT_W-1:0]  out_recv;
  logic              out_taken;

  logic [AW-1:0]     newest;
  logic [AW-1:0]     raddr;
  logic              rd_valid;
  logic [SNAP_W-1:0] rdata;
  snap_t             rd_snap;
  snap_t             wr_snap;
  logic              we;
  logic              out_free;
  logic              poll_fire;
  logic [TIME_W-1:0] age_old;
  logic [TIME_W-1:0] age_new;

  logic              div_start;
  logic              div_done;
  logic [CNT_W-1:0]  div_quot;

  assign newest    = (pos == '0) ? LAST_POS : pos - AW'(1);
  assign raddr     = (state == S_IDLE) ? pos : newest;
  assign rd_snap   = rd_valid ? snap_t'(rdata) : '0;
  assign out_free  = !out_valid || rate.ready;
  assign poll_fire = poll.valid && poll.ready;
  assign we        = (state == S_FINISH) && out_free && taken;
  assign wr_snap   = '{t_ms: now_r, sent: sent_r, received: recv_r};
  assign age_old   = now_r - rd_snap.t_ms;
  assign age_new   = now_r - rd_snap.t_ms;
  assign div_start = (state == S_START_SEND) || (state == S_START_RECV);

  swrm_ram #(
    .WIDTH (SNAP_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (pos),
    .wdata (wr_snap),
    .raddr (raddr),
    .rdata (rdata)
  );

  swrm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (elapsed),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    rd_valid <= snap_valid[raddr];
  end

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg.valid) begin
      interval <= cfg.data;
    end
  end

  // sequencer
  assign poll.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      snap_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      // drop the taken request unless a new one replaces it this cycle
      if (out_valid && rate.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (poll_fire) begin
            state <= S_RD_OLD;
          end
        end
        S_RD_OLD: begin
          state <= S_RD_NEW;
        end
        S_RD_NEW: begin
          state <= S_START_SEND;
        end
        S_START_SEND: begin
          state <= S_WAIT_SEND;
        end
        S_WAIT_SEND: begin
          if (div_done) begin
            state <= S_START_RECV;
          end
        end
        S_START_RECV: begin
          state <= S_WAIT_RECV;
        end
        S_WAIT_RECV: begin
          if (div_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (taken) begin
              snap_valid[pos] <= 1'b1;
              pos <= (pos == LAST_POS) ? '0 : pos + AW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (poll_fire) begin
      now_r  <= poll.now_ms;
      sent_r <= poll.sent_total;
      recv_r <= poll.received_total;
    end
    case (state)
      S_RD_OLD: begin
        // oldest snapshot: window length and byte deltas
        elapsed   <= (age_old == '0) ? ELAPSED_MIN : age_old;
        diff_sent <= sent_r - rd_snap.sent;
        diff_recv <= recv_r - rd_snap.received;
      end
      S_RD_NEW: begin
        taken <= (age_new >= TIME_W'(interval));
        num   <= NUM_W'(diff_sent) * NUM_W'(RATE_SCALE);
      end
      S_WAIT_SEND: begin
        if (div_done) begin
          send_q <= div_quot;
          num    <= NUM_W'(diff_recv) * NUM_W'(RATE_SCALE);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_send  <= send_q;
          out_recv  <= div_quot;
          out_taken <= taken;
        end
      end
      default: begin
      end
    endcase
  end

  assign rate.valid          = out_valid;
  assign rate.send_rate      = out_send;
  assign rate.receive_rate   = out_recv;
  assign rate.snapshot_taken = out_taken;

endmodule

>>> tb/sv/rate_meter_checker.sv
// Checker for the sliding window rate meter: watches the poll, rate and interval
// channels, predicts each rate request and compares it field by field.
// Depends on swrm_pkg and swrm_ifs.
module rate_meter_checker
  import swrm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  swrm_poll_if        poll,
  swrm_rate_if        rate,
  swrm_cfg_if         cfg,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);

  localparam int unsigned REPORT_CAP = 40;

  typedef struct packed {
    logic [CNT_W-1:0] send_rate;
    logic [CNT_W-1:0] receive_rate;
    logic             snapshot_taken;
  } rate_sample_t;

  logic [TIME_W-1:0]     snap_time     [RING_DEPTH];
  logic [CNT_W-1:0]      snap_sent     [RING_DEPTH];
  logic [CNT_W-1:0]      snap_received [RING_DEPTH];
  int unsigned           oldest_slot;
  logic [INTERVAL_W-1:0] interval_ms;
  rate_sample_t          expected_rates[$];
  int unsigned           fault_total = 0;

  assign mismatch_count = fault_total;

  task automatic report(input string what, input logic [CNT_W-1:0] got,
                        input logic [CNT_W-1:0] want);
    fault_total++;
    // keep the log short when the design is badly broken
    if (fault_total <= REPORT_CAP)
      $display("rate mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  function automatic logic [CNT_W-1:0] bytes_per_second(input logic [CNT_W-1:0] total,
                                                       input logic [CNT_W-1:0] old,
                                                       input logic [TIME_W-1:0] elapsed);
    logic [CNT_W-1:0] delta;
    logic [63:0]      scaled;
    logic [63:0]      quotient;
    delta    = total - old;
    scaled   = {32'b0, delta} * 64'(RATE_SCALE);
    quotient = scaled / {32'b0, elapsed};
    if (quotient > 64'h0000_0000_FFFF_FFFF)
      return '1;
    return quotient[CNT_W-1:0];
  endfunction

  // Rates against the oldest snapshot, then store this poll if the interval has run.
  task automatic advance_window(input logic [TIME_W-1:0] now,
                                input logic [CNT_W-1:0] sent,
                                input logic [CNT_W-1:0] received);
    int unsigned       newest_slot;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] since_newest;
    rate_sample_t      sample;
    newest_slot = (oldest_slot == 0) ? RING_DEPTH - 1 : oldest_slot - 1;
    elapsed     = now - snap_time[oldest_slot];
    if (elapsed == '0)
      elapsed = ELAPSED_MIN;
    sample.send_rate      = bytes_per_second(sent, snap_sent[oldest_slot], elapsed);
    sample.receive_rate   = bytes_per_second(received, snap_received[oldest_slot], elapsed);
    sample.snapshot_taken = 1'b0;
    since_newest = now - snap_time[newest_slot];
    if (since_newest >= {16'b0, interval_ms}) begin
      snap_time[oldest_slot]     = now;
      snap_sent[oldest_slot]     = sent;
      snap_received[oldest_slot] = received;
      oldest_slot = (oldest_slot + 1 == RING_DEPTH) ? 0 : oldest_slot + 1;
      sample.snapshot_taken = 1'b1;
    end
    expected_rates.push_back(sample);
  endtask

  always @(posedge clk) begin
    rate_sample_t want;
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        snap_time[i]     = '0;
        snap_sent[i]     = '0;
        snap_received[i] = '0;
      end
      oldest_slot = 0;
      interval_ms = INTERVAL_RESET;
      expected_rates.delete();
    end else begin
      if (rate.valid && rate.ready) begin
        if (expected_rates.size() == 0) begin
          report("rate request with none outstanding", rate.send_rate, '0);
        end else begin
          want = expected_rates.pop_front();
          if (rate.send_rate !== want.send_rate)
            report("send_rate", rate.send_rate, want.send_rate);
          if (rate.receive_rate !== want.receive_rate)
            report("receive_rate", rate.receive_rate, want.receive_rate);
          if (rate.snapshot_taken !== want.snapshot_taken)
            report("snapshot_taken", {31'b0, rate.snapshot_taken},
                   {31'b0, want.snapshot_taken});
        end
      end
      if (cfg.valid && cfg.ready)
        interval_ms = cfg.data;
      if (poll.valid && poll.ready)
        advance_window(poll.now_ms, poll.sent_total, poll.received_total);
    end
    outstanding <= expected_rates.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the sliding window rate meter: clock, reset, poll and
// interval stimulus, rate back-pressure and the verdict.
// Depends on swrm_pkg, swrm_ifs, the block and rate_meter_checker.
module tb_top;
  import swrm_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
  localparam int unsigned PHASE_POLLS    = 93;
  localparam int unsigned PHASES         = 7;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  bit          steady;

  logic [TIME_W-1:0] now_t;
  logic [CNT_W-1:0]  sent_t;
  logic [CNT_W-1:0]  recv_t;
  int unsigned       interval_now;
  logic [TIME_W-1:0] recent_times[$];

  swrm_poll_if poll_ch ();
  swrm_rate_if rate_ch ();
  swrm_cfg_if  cfg_ch ();

  sliding_window_rate_meter #(
    .RING_DEPTH(RING_DEPTH_DEF)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .poll (poll_ch),
    .rate (rate_ch),
    .cfg  (cfg_ch)
  );

  rate_meter_checker #(
    .RING_DEPTH(RING_DEPTH_DEF)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .poll           (poll_ch),
    .rate           (rate_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60)
      return 0;
    if (roll < 95)
      return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [CNT_W-1:0] byte_step();
    return ($urandom_range(0, 9) < 8) ? CNT_W'($urandom_range(0, 200000)) : CNT_W'($urandom);
  endfunction

  // Receiver back-pressure on the rate channel.
  initial begin
    int unsigned stall;
    rate_ch.ready <= 1'b0;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? idle_cycles() : 0;
      if (stall != 0) begin
        rate_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rate_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Hold the request until taken; leave valid high unless a gap follows.
  task automatic send_poll(input logic [TIME_W-1:0] t, input logic [CNT_W-1:0] s,
                           input logic [CNT_W-1:0] r);
    int unsigned gap;
    poll_ch.valid          <= 1'b1;
    poll_ch.now_ms         <= t;
    poll_ch.sent_total     <= s;
    poll_ch.received_total <= r;
    do @(posedge clk); while (!poll_ch.ready);
    gap = idle_cycles();
    if (gap != 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wander_poll();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      now_t  = $urandom;
      sent_t = $urandom;
      recv_t = $urandom;
    end else if (pick < 14) begin
      now_t -= $urandom_range(1, 5000);
    end else if (pick < 19 && recent_times.size() == RING_DEPTH_DEF) begin
      // land on the time of the oldest entry when every poll is stored
      now_t = recent_times[0];
    end else begin
      case ($urandom_range(0, 9))
        0: ;
        7, 8: now_t += $urandom_range(1, 5);
        9: now_t += $urandom;
        default: now_t += $urandom_range(0, 2 * interval_now + 2);
      endcase
      sent_t += byte_step();
      recv_t += byte_step();
    end
    if (recent_times.size() == RING_DEPTH_DEF)
      void'(recent_times.pop_front());
    recent_times.push_back(now_t);
    send_poll(now_t, sent_t, recv_t);
  endtask

  task automatic drain();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_interval(input logic [INTERVAL_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    interval_now = {16'b0, value};
  endtask

  initial begin
    logic [INTERVAL_W-1:0] settings[PHASES];
    rst                    <= 1'b1;
    poll_ch.valid          <= 1'b0;
    poll_ch.now_ms         <= '0;
    poll_ch.sent_total     <= '0;
    poll_ch.received_total <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.data            <= '0;
    steady       = 1'b0;
    interval_now = {16'b0, INTERVAL_RESET};
    settings = '{16'd1, 16'hFFFF, 16'd0, 16'd250, 16'd2, 16'd0, 16'd100};
    settings[5] = INTERVAL_W'($urandom_range(1, 65535));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero elapsed time against the cleared ring, then saturation
    send_poll(32'd0, 32'd0, 32'd0);
    send_poll(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_poll(32'd50, 32'd1000, 32'd2000);
    send_poll(32'd100, 32'd5000, 32'd0);
    // time going backwards shows up as a huge elapsed time
    send_poll(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_poll(32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555);
    send_poll(32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
    // totals wrap below the stored snapshot
    send_poll(32'h7FFF_FFFF + 32'd200, 32'h0000_0010, 32'h0000_0020);
    now_t  = 32'h7FFF_FFFF + 32'd200;
    sent_t = 32'hFFFF_FF00;
    recv_t = 32'hFFFF_F000;
    for (int i = 0; i < 14; i++) begin
      now_t  += 32'd100;
      sent_t += 32'd12345;
      recv_t += 32'd777;
      send_poll(now_t, sent_t, recv_t);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      set_interval(settings[phase]);
      steady = (phase % 3 == 1);
      repeat (PHASE_POLLS) wander_poll();
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
